// ----- rtl/core/spmq_pkg.sv -----
package spmq_pkg;

  // Sizing of the class table and the shared entry pool
  localparam int unsigned NUM_CLASSES = 16;
  localparam int unsigned CAPACITY    = 64;

  localparam int unsigned CLS_W = $clog2(NUM_CLASSES);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Fixed field widths of the transaction ports
  localparam int unsigned REQ_W = 2;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned PRI_W = 4;
  localparam int unsigned STS_W = 2;
  localparam int unsigned CFG_W = 5;

  // Reset value of the class limit register
  localparam logic [CFG_W-1:0] CLASSES_RESET = 5'd16;

  typedef logic [CLS_W-1:0] cls_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PEEK   = 2'd2
  } req_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

// ----- rtl/core/spmq_ram.sv -----
module spmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/strict_priority_multi_queue.sv -----
// Strict-priority multi-queue over a shared pool of linked entries.
// Request channel (in_valid_i / in_stall_o): req_type_i selects insert,
// remove head or peek head; item_value_i and item_priority_i serve an insert.
// Response channel (out_valid_o / out_stall_i): exactly one response per
// request, carrying status_o, out_value_o and out_priority_o.
// Class 0 is served first; within a class values leave in arrival order.
// The user must have cfg_we_i write cfg_wdata_i into the class limit only
// while the block is idle; the block itself does not enforce it. A taken
// request sets busy; its response is registered once the response register
// is free. No new request is taken until the last one finishes: the link and
// value memories are read on accept and written back in the update cycle.
// While the receiver stalls a finished response, the response register
// holds it and a pending request waits in its update cycle.
// Reset empties every class, chains all entries into the free list (tracked
// by a fill count, no clearing pass) and sets the class limit to 16; the
// block accepts requests in the first cycle after reset.
module strict_priority_multi_queue
  import spmq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic signed [VAL_W-1:0] item_value_i,
  input  logic [PRI_W-1:0]        item_priority_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STS_W-1:0]        status_o,
  output logic signed [VAL_W-1:0] out_value_o,
  output logic [PRI_W-1:0]        out_priority_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i
);

  // Control state
  logic             busy_q;
  logic             out_valid_q, out_valid_d;
  logic [CFG_W-1:0] cfg_q;
  cnt_t             occ_q [NUM_CLASSES];
  cnt_t             occ_d [NUM_CLASSES];
  idx_t             free_head_q, free_head_d;
  cnt_t             used_q, used_d;
  cnt_t             fill_q, fill_d;

  // Payload state
  idx_t head_q [NUM_CLASSES];
  idx_t head_d [NUM_CLASSES];
  idx_t tail_q [NUM_CLASSES];
  idx_t tail_d [NUM_CLASSES];

  // Captured request
  req_e                    req_q;
  logic signed [VAL_W-1:0] val_q;
  logic [PRI_W-1:0]        pri_q;
  cls_t                    cls_q;
  logic                    empty_q;

  // Response register
  status_e                 sts_q, sts_d;
  logic signed [VAL_W-1:0] oval_q, oval_d;
  logic [PRI_W-1:0]        opri_q, opri_d;

  // Accept-time lookup
  logic accept;
  logic finish;
  cls_t cls_sel;
  logic found;
  idx_t head_sel;

  // Memory ports
  logic             val_we;
  idx_t             val_waddr;
  logic [VAL_W-1:0] val_rdata;
  logic             link_we;
  idx_t             link_waddr;
  idx_t             link_wdata;
  idx_t             link_raddr;
  idx_t             link_rdata;

  // Update-cycle helpers
  cls_t        ins_cls;
  idx_t        rem_e;
  logic [31:0] limit;
  logic        out_of_range;
  logic        link_valid;
  idx_t        next_free;

  assign accept      = in_valid_i & ~in_stall_o;
  assign in_stall_o  = busy_q;
  assign finish      = busy_q & (~out_valid_q | ~out_stall_i);

  // Find the lowest non-empty class
  always_comb begin
    cls_sel = '0;
    found   = 1'b0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (occ_q[k] != '0) begin
        cls_sel = cls_t'(k);
        found   = 1'b1;
      end
    end
  end

  assign head_sel   = head_q[cls_sel];
  assign link_raddr = (req_e'(req_type_i) == REQ_INSERT) ? free_head_q : head_sel;

  spmq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_q),
    .re_i    (accept),
    .raddr_i (head_sel),
    .rdata_o (val_rdata)
  );

  spmq_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (accept),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  // Resolve the free-list successor: entries past the fill count have never been
  // written and follow the reset chain to the next index
  assign link_valid = cnt_t'(free_head_q) < fill_q;
  assign next_free  = (32'(free_head_q) + 32'd1 < 32'(CAPACITY)) ?
                      idx_t'(32'(free_head_q) + 32'd1) : '0;

  // Clamp the class limit and check the insert priority
  assign limit        = (32'(cfg_q) < 32'(NUM_CLASSES)) ? 32'(cfg_q) : 32'(NUM_CLASSES);
  assign out_of_range = 32'(pri_q) >= limit;
  assign ins_cls      = cls_t'(pri_q);
  assign rem_e        = head_q[cls_q];
  assign val_waddr    = free_head_q;

  // Update the lists and build the response
  always_comb begin
    occ_d       = occ_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_head_d = free_head_q;
    used_d      = used_q;
    fill_d      = fill_q;
    val_we      = 1'b0;
    link_we     = 1'b0;
    link_waddr  = tail_q[ins_cls];
    link_wdata  = free_head_q;
    sts_d       = ST_OK;
    oval_d      = '0;
    opri_d      = '0;
    if (finish) begin
      case (req_q)
        REQ_INSERT: begin
          if (out_of_range) begin
            sts_d = ST_RANGE;
          end else if (used_q == cnt_t'(CAPACITY)) begin
            sts_d = ST_FULL;
          end else begin
            val_we = 1'b1;
            if (occ_q[ins_cls] == '0) begin
              head_d[ins_cls] = free_head_q;
            end else begin
              link_we = 1'b1;
            end
            tail_d[ins_cls] = free_head_q;
            occ_d[ins_cls]  = occ_q[ins_cls] + cnt_t'(1);
            used_d          = used_q + cnt_t'(1);
            free_head_d     = link_valid ? link_rdata : next_free;
            if (!link_valid) begin
              fill_d = fill_q + cnt_t'(1);
            end
          end
        end
        REQ_REMOVE, REQ_PEEK: begin
          if (empty_q) begin
            sts_d = ST_EMPTY;
          end else begin
            oval_d = val_rdata;
            opri_d = PRI_W'(cls_q);
            if (req_q == REQ_REMOVE) begin
              head_d[cls_q] = link_rdata;
              occ_d[cls_q]  = occ_q[cls_q] - cnt_t'(1);
              link_we       = 1'b1;
              link_waddr    = rem_e;
              free_head_d   = rem_e;
              used_d        = used_q - cnt_t'(1);
            end
          end
        end
        default: begin
          sts_d = ST_OK;
        end
      endcase
    end
  end

  // Response valid: load on finish, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q       <= CLASSES_RESET;
      free_head_q <= '0;
      used_q      <= '0;
      fill_q      <= '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        occ_q[k] <= '0;
      end
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      free_head_q <= free_head_d;
      used_q      <= used_d;
      fill_q      <= fill_d;
      occ_q       <= occ_d;
    end
  end

  // Payload registers: class pointers, captured request, response
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
    if (accept) begin
      req_q   <= req_e'(req_type_i);
      val_q   <= item_value_i;
      pri_q   <= item_priority_i;
      cls_q   <= cls_sel;
      empty_q <= ~found;
    end
    if (finish) begin
      sts_q  <= sts_d;
      oval_q <= oval_d;
      opri_q <= opri_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = sts_q;
  assign out_value_o    = oval_q;
  assign out_priority_o = opri_q;

endmodule
